@@ design/bucketed_hash_frequency_table_top_assert.svh @@
// assertion macros for the bucketed hash frequency table
`ifndef BUCKETED_HASH_FREQUENCY_TABLE_TOP_ASSERT_SVH
`define BUCKETED_HASH_FREQUENCY_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BHFT_ASSERT(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) \
		else $error("bhft assertion failed");
`define BHFT_NEVER(label, clock, rst_n, cond) \
	`BHFT_ASSERT(label, clock, rst_n, !(cond))
`else
`define BHFT_ASSERT(label, clock, rst_n, prop)
`define BHFT_NEVER(label, clock, rst_n, cond)
`endif

`endif

@@ design/bhft_pkg.sv @@
// shared types and constants for the bucketed hash frequency table
`timescale 1ns / 1ps

package bhft_pkg;

	localparam int BUCKET_INDEX_BITS_DEF = 10;
	localparam int BUCKET_SLOTS_DEF      = 4;

	localparam int KEY_W = 64;
	localparam int LEN_W = 10;
	localparam int WGT_W = 16;
	localparam int CNT_W = 32;
	localparam int CFG_W = 4;

	localparam int IN_TDATA_W  = 96;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_TUSER_W = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;
	localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [LEN_W-1:0] len;
		logic [KEY_W-1:0] key;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic             dropped;
		logic             found;
		logic [CNT_W-1:0] count;
	} res_t;

	typedef struct packed {
		logic row_we;
		logic fill_we;
	} wr_ctl_t;

endpackage

@@ design/bucketed_hash_frequency_table_top.sv @@
// top level of the bucketed hash frequency table
//
// channel   dir  fields (low bit up)
// s_axis    in   tuser: cmd | tdata: key, token_length, weight, zero pad
// m_axis    out  tuser: found, dropped | tdata: count
// cfg       in   cfg_wdata: index_bits
//
// the bucket row and fill count of each item are read from memories
// with registered read data, then compared, updated and written back
// before the next item may read. the result sits in an output register,
// so one more item is read while it waits. after reset the fill memory
// is cleared one bucket a cycle, all 2**BUCKET_INDEX_BITS buckets, with
// s_axis held not ready; configuration writes are taken throughout.
`timescale 1ns / 1ps

module bucketed_hash_frequency_table_top #(
	parameter int BUCKET_INDEX_BITS = bhft_pkg::BUCKET_INDEX_BITS_DEF,
	parameter int BUCKET_SLOTS      = bhft_pkg::BUCKET_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [bhft_pkg::CFG_W-1:0]          cfg_wdata,    // index_bits
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [bhft_pkg::IN_TDATA_W-1:0]     s_axis_tdata, // key, token_length, weight
	input  logic [bhft_pkg::IN_TUSER_W-1:0]     s_axis_tuser, // cmd
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [bhft_pkg::OUT_TDATA_W-1:0]    m_axis_tdata, // count
	output logic [bhft_pkg::OUT_TUSER_W-1:0]    m_axis_tuser  // found, dropped
);

	`include "bucketed_hash_frequency_table_top_assert.svh"

	localparam int IB     = BUCKET_INDEX_BITS;
	localparam int SLOTS  = BUCKET_SLOTS;
	localparam int FILL_W = $clog2(SLOTS + 1);
	localparam int ROW_W  = SLOTS * bhft_pkg::SLOT_W;
	localparam int KW     = bhft_pkg::KEY_W;
	localparam int LW     = bhft_pkg::LEN_W;
	localparam int WW     = bhft_pkg::WGT_W;

	logic [bhft_pkg::CFG_W-1:0] index_bits_q;
	logic                       clear_q;
	logic [IB-1:0]              clr_addr_q;
	logic                       busy_s1;
	logic                       out_valid_q;
	bhft_pkg::res_t             out_res_q;

	bhft_pkg::cmd_t             cmd_s1;
	logic [KW-1:0]              key_s1;
	logic [LW-1:0]              len_s1;
	logic [WW-1:0]              wgt_s1;
	logic [IB-1:0]              bkt_s1;

	logic                       in_acc;
	logic                       done_s1;
	logic [KW-1:0]              key_in;
	logic [IB-1:0]              bkt_in;

	bhft_pkg::slot_t [SLOTS-1:0] row_rd;
	bhft_pkg::slot_t [SLOTS-1:0] row_wr;
	logic [FILL_W-1:0]           fill_rd;
	logic [FILL_W-1:0]           fill_new;
	bhft_pkg::res_t              res;
	bhft_pkg::wr_ctl_t           ctl;

	logic                        fill_we;
	logic [IB-1:0]               fill_waddr;
	logic [FILL_W-1:0]           fill_wdata;

	assign key_in = s_axis_tdata[KW-1:0];

	// low key bits, limited to the configured width
	always_comb begin
		for (int i = 0; i < IB; i++) begin
			bkt_in[i] = key_in[i] && (32'(index_bits_q) > i);
		end
	end

	assign s_axis_tready = !clear_q && !busy_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign done_s1       = busy_s1 && (!out_valid_q || m_axis_tready);

	assign fill_we    = clear_q || (done_s1 && ctl.fill_we);
	assign fill_waddr = clear_q ? clr_addr_q : bkt_s1;
	assign fill_wdata = clear_q ? '0 : fill_new;

	bhft_ram #(
		.WIDTH  (ROW_W),
		.ADDR_W (IB)
	) u_slot_ram (
		.clk   (clk),
		.we    (done_s1 && ctl.row_we),
		.waddr (bkt_s1),
		.wdata (row_wr),
		.re    (in_acc),
		.raddr (bkt_in),
		.rdata (row_rd)
	);

	bhft_ram #(
		.WIDTH  (FILL_W),
		.ADDR_W (IB)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (in_acc),
		.raddr (bkt_in),
		.rdata (fill_rd)
	);

	bhft_match #(
		.SLOTS  (SLOTS),
		.FILL_W (FILL_W)
	) u_match (
		.cmd      (cmd_s1),
		.key      (key_s1),
		.len      (len_s1),
		.weight   (wgt_s1),
		.fill     (fill_rd),
		.row      (row_rd),
		.res      (res),
		.ctl      (ctl),
		.wr_row   (row_wr),
		.new_fill (fill_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= bhft_pkg::CFG_RESET;
			clear_q      <= 1'b1;
			clr_addr_q   <= '0;
			busy_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				index_bits_q <= cfg_wdata;
			end
			if (clear_q) begin
				clr_addr_q <= clr_addr_q + IB'(1);
				if (&clr_addr_q) begin
					clear_q <= 1'b0;
				end
			end
			if (in_acc) begin
				busy_s1 <= 1'b1;
			end else if (done_s1) begin
				busy_s1 <= 1'b0;
			end
			if (done_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= bhft_pkg::cmd_t'(s_axis_tuser[0]);
			key_s1 <= key_in;
			len_s1 <= s_axis_tdata[KW+LW-1:KW];
			wgt_s1 <= s_axis_tdata[KW+LW+WW-1:KW+LW];
			bkt_s1 <= bkt_in;
		end
		if (done_s1) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_res_q.count;
	assign m_axis_tuser  = {out_res_q.dropped, out_res_q.found};

	`BHFT_NEVER(a_no_accept_in_clear, clk, arst_n, clear_q && s_axis_tready)
	`BHFT_NEVER(a_no_work_in_clear, clk, arst_n, clear_q && busy_s1)
	`BHFT_ASSERT(a_stall_holds_s1, clk, arst_n, busy_s1 && !done_s1 |=> busy_s1)
	`BHFT_ASSERT(a_done_shows_result, clk, arst_n, done_s1 |=> m_axis_tvalid)
	`BHFT_NEVER(a_found_and_dropped, clk, arst_n, m_axis_tvalid && out_res_q.found && out_res_q.dropped)

endmodule

@@ design/bhft_ram.sv @@
// simple dual-port synchronous ram with registered read data
`timescale 1ns / 1ps

module bhft_ram #(
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_W];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/bhft_match.sv @@
// bucket row compare, saturating count update and append logic
`timescale 1ns / 1ps

module bhft_match #(
	parameter int SLOTS  = bhft_pkg::BUCKET_SLOTS_DEF,
	parameter int FILL_W = $clog2(SLOTS + 1)
) (
	input  bhft_pkg::cmd_t                 cmd,
	input  logic [bhft_pkg::KEY_W-1:0]     key,
	input  logic [bhft_pkg::LEN_W-1:0]     len,
	input  logic [bhft_pkg::WGT_W-1:0]     weight,
	input  logic [FILL_W-1:0]              fill,
	input  bhft_pkg::slot_t [SLOTS-1:0]    row,
	output bhft_pkg::res_t                 res,
	output bhft_pkg::wr_ctl_t              ctl,
	output bhft_pkg::slot_t [SLOTS-1:0]    wr_row,
	output logic [FILL_W-1:0]              new_fill
);

	localparam logic [FILL_W-1:0] SLOTS_F = FILL_W'(SLOTS);

	logic [SLOTS-1:0]              hit;
	logic [SLOTS-1:0]              first;
	logic [bhft_pkg::CNT_W-1:0]    hit_cnt;
	logic [bhft_pkg::CNT_W:0]      sum;
	logic [bhft_pkg::CNT_W-1:0]    sat_cnt;
	logic                          full;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			hit[i] = (FILL_W'(i) < fill) && (row[i].key == key) && (row[i].len == len);
		end
		// lowest matching slot, one-hot
		first = hit & ~(hit - SLOTS'(1));
		hit_cnt = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (first[i]) begin
				hit_cnt = hit_cnt | row[i].count;
			end
		end
		sum     = {1'b0, hit_cnt} + (bhft_pkg::CNT_W + 1)'(weight);
		sat_cnt = sum[bhft_pkg::CNT_W] ? bhft_pkg::COUNT_MAX : sum[bhft_pkg::CNT_W-1:0];
		full    = fill >= SLOTS_F;

		res      = '0;
		ctl      = '0;
		wr_row   = row;
		new_fill = fill + FILL_W'(1);

		if (|hit) begin
			res.found = 1'b1;
			if (cmd == bhft_pkg::CMD_INSERT) begin
				res.count  = sat_cnt;
				ctl.row_we = 1'b1;
				for (int i = 0; i < SLOTS; i++) begin
					if (first[i]) begin
						wr_row[i].count = sat_cnt;
					end
				end
			end else begin
				res.count = hit_cnt;
			end
		end else if (cmd == bhft_pkg::CMD_INSERT) begin
			if (full) begin
				res.dropped = 1'b1;
			end else begin
				res.count   = bhft_pkg::CNT_W'(weight);
				ctl.row_we  = 1'b1;
				ctl.fill_we = 1'b1;
				for (int i = 0; i < SLOTS; i++) begin
					if (FILL_W'(i) == fill) begin
						wr_row[i].count = bhft_pkg::CNT_W'(weight);
						wr_row[i].len   = len;
						wr_row[i].key   = key;
					end
				end
			end
		end
	end

endmodule

@@ tb/bucketed_hash_frequency_table_top_tb.sv @@
// self-checking testbench for the bucketed hash frequency table top level
`timescale 1ns / 1ps

module bucketed_hash_frequency_table_top_tb;
	import bhft_pkg::*;

	localparam int NB          = 1 << BUCKET_INDEX_BITS_DEF;
	localparam int NS          = BUCKET_SLOTS_DEF;
	localparam int PAD_W       = IN_TDATA_W - KEY_W - LEN_W - WGT_W;
	localparam int POOL_N      = 32;
	localparam int PHASE_ITEMS = 185;
	localparam int SAT_ITEMS   = 100;
	localparam int STALL_LIMIT = 5000;
	localparam logic [KEY_W-1:0] ONES = '1;

	typedef enum logic {
		ROW_ITEM = 1'b0,
		ROW_CFG  = 1'b1
	} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
		logic [WGT_W-1:0] wgt;
		logic [CFG_W-1:0] cfg;
		bit               typed;
		res_t             want;
	} probe_row_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_wen       = 1'b0;
	logic [CFG_W-1:0]       cfg_wdata     = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0; // key, token_length, weight, zero pad
	logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0; // cmd
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;       // count
	logic [OUT_TUSER_W-1:0] m_axis_tuser;       // found, dropped

	logic [KEY_W-1:0] shadow_key [NB*NS];
	logic [LEN_W-1:0] shadow_len [NB*NS];
	logic [CNT_W-1:0] shadow_cnt [NB*NS];
	int               shadow_fill [NB] = '{default: 0};
	logic [CFG_W-1:0] index_bits_sh = CFG_RESET;

	res_t             pending_tally [$];
	probe_row_t       probe_rows [$];
	logic [KEY_W-1:0] hot_key [POOL_N];
	logic [LEN_W-1:0] hot_len [POOL_N];

	bit jitter_on   = 1'b1;
	int rx_hold     = 0;
	int fault_cnt   = 0;
	int stall_count = 0;

	bucketed_hash_frequency_table_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [KEY_W-1:0] bucket_mask();
		int eff;
		eff = (index_bits_sh > BUCKET_INDEX_BITS_DEF) ? BUCKET_INDEX_BITS_DEF : int'(index_bits_sh);
		return (64'd1 << eff) - 64'd1;
	endfunction

	function automatic res_t tally(cmd_t c, logic [KEY_W-1:0] k, logic [LEN_W-1:0] l,
			logic [WGT_W-1:0] w);
		res_t        r;
		int          b;
		int          s;
		int          i;
		int          hit;
		logic [32:0] sum;
		r   = '0;
		b   = int'(k & bucket_mask());
		hit = -1;
		for (i = 0; i < shadow_fill[b]; i++) begin
			if (hit < 0 && shadow_key[b*NS+i] == k && shadow_len[b*NS+i] == l)
				hit = i;
		end
		if (hit >= 0) begin
			s       = b * NS + hit;
			r.found = 1'b1;
			if (c == CMD_INSERT) begin
				sum           = {1'b0, shadow_cnt[s]} + 33'(w);
				shadow_cnt[s] = sum[32] ? COUNT_MAX : sum[CNT_W-1:0];
			end
			r.count = shadow_cnt[s];
		end else if (c == CMD_INSERT) begin
			if (shadow_fill[b] >= NS) begin
				r.dropped = 1'b1;
			end else begin
				s              = b * NS + shadow_fill[b];
				shadow_key[s]  = k;
				shadow_len[s]  = l;
				shadow_cnt[s]  = {{(CNT_W-WGT_W){1'b0}}, w};
				shadow_fill[b] = shadow_fill[b] + 1;
				r.count        = shadow_cnt[s];
			end
		end
		return r;
	endfunction

	function automatic void refresh_pool(int keep);
		logic [KEY_W-1:0] m;
		logic [KEY_W-1:0] home [3];
		int               i;
		m = bucket_mask();
		for (i = 0; i < 3; i++)
			home[i] = {$urandom, $urandom} & m;
		for (i = keep; i < POOL_N; i++) begin
			if (i > 0 && $urandom_range(0, 3) == 0)
				hot_key[i] = hot_key[i-1];
			else
				hot_key[i] = ({$urandom, $urandom} & ~m) | home[$urandom_range(0, 2)];
			hot_len[i] = LEN_W'($urandom_range(0, 1023));
		end
	endfunction

	function automatic void add_item(cmd_t c, logic [KEY_W-1:0] k, logic [LEN_W-1:0] l,
			logic [WGT_W-1:0] w, bit typed, logic [CNT_W-1:0] cnt, bit f, bit d);
		probe_row_t row;
		row.kind       = ROW_ITEM;
		row.cmd        = c;
		row.key        = k;
		row.len        = l;
		row.wgt        = w;
		row.cfg        = '0;
		row.typed      = typed;
		row.want.count = cnt;
		row.want.found = f;
		row.want.dropped = d;
		probe_rows.push_back(row);
	endfunction

	function automatic void add_cfg(logic [CFG_W-1:0] v);
		probe_row_t row;
		row.kind  = ROW_CFG;
		row.cmd   = CMD_INSERT;
		row.key   = '0;
		row.len   = '0;
		row.wgt   = '0;
		row.cfg   = v;
		row.typed = 1'b0;
		row.want  = '0;
		probe_rows.push_back(row);
	endfunction

	task automatic drive_item(cmd_t c, logic [KEY_W-1:0] k, logic [LEN_W-1:0] l,
			logic [WGT_W-1:0] w, bit typed, res_t want);
		int   gap;
		res_t r;
		gap = jitter_on ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{PAD_W{1'b0}}, w, l, k};
		s_axis_tuser  <= c;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		r = tally(c, k, l, w);
		pending_tally.push_back(typed ? want : r);
	endtask

	task automatic settle_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_tally.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_index_bits(logic [CFG_W-1:0] v);
		settle_idle();
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		index_bits_sh = v;
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	task automatic check_beat(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
		res_t want;
		res_t got;
		got.count   = data[CNT_W-1:0];
		got.found   = user[0];
		got.dropped = user[1];
		if (pending_tally.size() == 0) begin
			fault_cnt++;
			if (fault_cnt <= 10)
				$display("%0t: unexpected beat count %h found %b dropped %b",
					$realtime, got.count, got.found, got.dropped);
		end else begin
			want = pending_tally.pop_front();
			if (want.count !== got.count || want.found !== got.found ||
					want.dropped !== got.dropped) begin
				fault_cnt++;
				if (fault_cnt <= 10)
					$display("%0t: mismatch count exp %h got %h found exp %b got %b dropped exp %b got %b",
						$realtime, want.count, got.count, want.found, got.found,
						want.dropped, got.dropped);
			end
		end
	endtask

	initial begin : receiver
		int gap;
		forever begin
			if (rx_hold > 0) begin
				gap     = rx_hold;
				rx_hold = 0;
			end else begin
				gap = jitter_on ? $urandom_range(0, 3) : 0;
			end
			@(negedge clk);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			check_beat(m_axis_tdata, m_axis_tuser);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0] phase_ib [8];
		logic [KEY_W-1:0] k;
		logic [LEN_W-1:0] l;
		logic [WGT_W-1:0] w;
		cmd_t             c;
		probe_row_t       row;
		res_t             none;
		int               pick;
		int               i;
		int               ph;
		int               n;

		none     = '0;
		phase_ib = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd4, 4'd0, 4'd2, 4'd0};
		phase_ib[5] = CFG_W'($urandom_range(0, 15));
		phase_ib[7] = CFG_W'($urandom_range(0, 15));

		// bucket 0 is probed and filled, then bucket 0x3ff gets four distinct slots, then overflows
		add_item(CMD_LOOKUP, 64'd0, 10'd0, 16'd0, 1, 32'd0, 0, 0);
		add_item(CMD_INSERT, 64'd0, 10'd0, 16'd0, 1, 32'd0, 0, 0);
		add_item(CMD_INSERT, 64'd0, 10'd0, 16'hFFFF, 1, 32'h0000_FFFF, 1, 0);
		add_item(CMD_LOOKUP, 64'd0, 10'd0, 16'hFFFF, 1, 32'h0000_FFFF, 1, 0);
		add_item(CMD_INSERT, ONES, 10'h3FF, 16'hFFFF, 1, 32'h0000_FFFF, 0, 0);
		add_item(CMD_INSERT, ONES, 10'h3FE, 16'd1, 0, 32'd0, 0, 0);
		add_item(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 10'h3FF, 16'd2, 0, 32'd0, 0, 0);
		add_item(CMD_INSERT, 64'hFFFF_FFFF_0000_03FF, 10'd0, 16'd3, 0, 32'd0, 0, 0);
		add_item(CMD_INSERT, 64'h8000_0000_0000_03FF, 10'd5, 16'd9, 1, 32'd0, 0, 1);
		add_item(CMD_LOOKUP, 64'h8000_0000_0000_03FF, 10'd5, 16'd0, 1, 32'd0, 0, 0);
		add_item(CMD_INSERT, ONES, 10'h3FF, 16'hFFFF, 1, 32'h0001_FFFE, 1, 0);
		add_item(CMD_LOOKUP, ONES, 10'h3FE, 16'd0, 0, 32'd0, 0, 0);
		add_item(CMD_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 10'h3FF, 16'hFFFF, 0, 32'd0, 0, 0);
		add_item(CMD_INSERT, 64'hAAAA_5555_AAAA_57FF, 10'h155, 16'h5555, 1, 32'd0, 0, 1);
		// zero index width folds every key onto bucket 0
		add_cfg(4'd0);
		add_item(CMD_LOOKUP, ONES, 10'h3FF, 16'd0, 1, 32'd0, 0, 0);
		add_item(CMD_INSERT, 64'd1, 10'd7, 16'd100, 0, 32'd0, 0, 0);
		add_item(CMD_INSERT, 64'h5555_AAAA_5555_AAAA, 10'h2AA, 16'hAAAA, 0, 32'd0, 0, 0);
		add_item(CMD_INSERT, ONES, 10'h3FF, 16'd6, 0, 32'd0, 0, 0);
		add_item(CMD_INSERT, 64'd4, 10'd0, 16'd7, 1, 32'd0, 0, 1);
		add_item(CMD_INSERT, 64'd0, 10'd0, 16'd1, 0, 32'd0, 0, 0);
		// oversized width clamps to the full index
		add_cfg(4'd15);
		add_item(CMD_LOOKUP, 64'd0, 10'd0, 16'd0, 0, 32'd0, 0, 0);
		add_item(CMD_LOOKUP, 64'd1, 10'd7, 16'd0, 1, 32'd0, 0, 0);
		add_item(CMD_INSERT, 64'd1, 10'd7, 16'd1, 1, 32'd1, 0, 0);
		add_cfg(4'd10);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < probe_rows.size(); i++) begin
			row = probe_rows[i];
			if (row.kind == ROW_CFG)
				write_index_bits(row.cfg);
			else
				drive_item(row.cmd, row.key, row.len, row.wgt, row.typed, row.want);
		end

		// back to back heavy weight on one hot key
		jitter_on = 1'b0;
		for (n = 0; n < SAT_ITEMS; n++)
			drive_item(CMD_INSERT, 64'h0123_4567_89AB_CDEF, 10'd3, 16'hFFFF, 0, none);
		drive_item(CMD_INSERT, 64'h0123_4567_89AB_CDEF, 10'd3, 16'd0, 0, none);
		drive_item(CMD_LOOKUP, 64'h0123_4567_89AB_CDEF, 10'd3, 16'd0, 0, none);

		for (ph = 0; ph < 8; ph++) begin
			write_index_bits(phase_ib[ph]);
			refresh_pool(ph == 0 ? 0 : 8);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					jitter_on = ($urandom_range(0, 3) != 0);
				if (ph == 2 && n == 60)
					rx_hold = 200;
				if (ph == 5 && n == 100)
					settle_idle();
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					i = $urandom_range(0, POOL_N - 1);
					k = hot_key[i];
					l = hot_len[i];
					c = ($urandom_range(0, 9) < 6) ? CMD_INSERT : CMD_LOOKUP;
				end else begin
					k = {$urandom, $urandom};
					l = LEN_W'($urandom_range(0, 1023));
					c = cmd_t'($urandom_range(0, 1));
				end
				pick = $urandom_range(0, 9);
				if (pick == 0)
					w = '0;
				else if (pick == 1)
					w = '1;
				else
					w = WGT_W'($urandom);
				drive_item(c, k, l, w, 0, none);
			end
		end

		settle_idle();
		repeat (10) @(posedge clk);
		if (fault_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
